FILE: design/ebml_element_header_parser_defines.svh
// Assertion macros for the EBML element header parser.
`ifndef EBML_ELEMENT_HEADER_PARSER_DEFINES_SVH
`define EBML_ELEMENT_HEADER_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every clock edge out of reset.
`define EBML_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ebml assertion failed");

// Next-cycle implication.
`define EBML_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ebml assertion failed");

`else

`define EBML_ASSERT_NOW(label, ante, cons)
`define EBML_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: design/ebml_pkg.sv
// Shared types and constants of the EBML element header parser.
package ebml_pkg;

   localparam int VALUE_W     = 56;
   localparam int LEN_W       = 4;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 176;

   localparam logic       CMD_LOAD = 1'b0;
   localparam logic       CMD_BYTE = 1'b1;
   localparam logic [7:0] VINT_PAYLOAD_MASK = 8'h7F;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_LEAD    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVER_BUDGET = 2'd2;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_HEADER,
      KIND_ERROR
   } ebml_kind_type;

   // Queue entry from the decoder to the budget stage.
   // For a load, size carries the new budget.
   typedef struct packed {
      ebml_kind_type        kind;
      logic [VALUE_W-1:0]   id;
      logic [VALUE_W-1:0]   size;
      logic [LEN_W-1:0]     id_len;
      logic [LEN_W-1:0]     size_len;
      logic [VALUE_W:0]     total;
      logic                 bounded;
   } ebml_entry_type;

   typedef struct packed {
      logic [VALUE_W-1:0]   id;
      logic [VALUE_W-1:0]   size;
      logic [LEN_W-1:0]     id_len;
      logic [LEN_W-1:0]     size_len;
      logic [STATUS_W-1:0]  status;
      logic [VALUE_W-1:0]   left;
      logic                 done;
   } ebml_result_type;

endpackage

FILE: design/ebml_queue.sv
// Short register queue between the header decoder and the budget stage.
module ebml_queue
   import ebml_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  ebml_entry_type push_entry,
   output logic           full,
   input  logic           pop,
   output logic           head_valid,
   output ebml_entry_type head_entry
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   ebml_entry_type   entry_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff,  count_in;

   assign full       = (count_ff == (AW+1)'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: design/ebml_front.sv
// Header decoder: takes words, decodes the ID and size integers, queues events.
module ebml_front
   import ebml_pkg::*;
#(
   parameter int MAX_VINT_BYTES = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic               command,
   input  logic [7:0]         data_byte,
   input  logic [VALUE_W-1:0] parent_size,
   input  logic               parent_bounded,
   output logic               push_valid,
   output ebml_entry_type     push_entry
);

   logic               phase_is_size_ff, phase_is_size_in;
   logic [2:0]         pending_ff,       pending_in;
   logic [VALUE_W-1:0] acc_ff,           acc_in;
   logic [LEN_W-1:0]   cur_len_ff,       cur_len_in;
   logic [VALUE_W-1:0] held_id_ff,       held_id_in;
   logic [LEN_W-1:0]   held_len_ff,      held_len_in;

   logic [LEN_W-1:0]   lead_len;
   logic [7:0]         lead_mask;
   logic               complete;
   logic [VALUE_W-1:0] done_val;
   logic [LEN_W-1:0]   done_len;

   // Length from the position of the highest set bit; zero for a zero byte.
   always_comb begin
      lead_len = '0;
      for (int i = 0; i < 8; i++) begin
         if (data_byte[i]) begin
            lead_len = LEN_W'(8 - i);
         end
      end
      lead_mask = VINT_PAYLOAD_MASK >> (lead_len - 1'b1);
   end

   always_comb begin
      phase_is_size_in = phase_is_size_ff;
      pending_in       = pending_ff;
      acc_in           = acc_ff;
      cur_len_in       = cur_len_ff;
      held_id_in       = held_id_ff;
      held_len_in      = held_len_ff;
      complete         = 1'b0;
      done_val         = acc_ff;
      done_len         = cur_len_ff;
      push_valid       = 1'b0;
      push_entry       = '0;
      push_entry.kind  = KIND_ERROR;

      if (take) begin
         if (command == CMD_LOAD) begin
            push_valid         = 1'b1;
            push_entry.kind    = KIND_LOAD;
            push_entry.size    = parent_size;
            push_entry.bounded = parent_bounded;
            phase_is_size_in   = 1'b0;
            pending_in         = '0;
         end else if (pending_ff != '0) begin
            acc_in     = {acc_ff[VALUE_W-9:0], data_byte};
            pending_in = pending_ff - 1'b1;
            done_val   = acc_in;
            complete   = (pending_ff == 3'd1);
         end else if (lead_len == '0 || lead_len > LEN_W'(MAX_VINT_BYTES)) begin
            push_valid          = 1'b1;
            push_entry.kind     = KIND_ERROR;
            push_entry.id       = phase_is_size_ff ? held_id_ff  : '0;
            push_entry.id_len   = phase_is_size_ff ? held_len_ff : '0;
            phase_is_size_in    = 1'b0;
            pending_in          = '0;
         end else begin
            cur_len_in = lead_len;
            acc_in     = VALUE_W'(data_byte & lead_mask);
            pending_in = 3'(lead_len - 1'b1);
            done_val   = acc_in;
            done_len   = lead_len;
            complete   = (lead_len == LEN_W'(1));
         end

         if (complete) begin
            if (!phase_is_size_ff) begin
               held_id_in       = done_val;
               held_len_in      = done_len;
               phase_is_size_in = 1'b1;
            end else begin
               push_valid          = 1'b1;
               push_entry.kind     = KIND_HEADER;
               push_entry.id       = held_id_ff;
               push_entry.size     = done_val;
               push_entry.id_len   = held_len_ff;
               push_entry.size_len = done_len;
               push_entry.total    = {1'b0, done_val} + (VALUE_W+1)'(held_len_ff)
                                     + (VALUE_W+1)'(done_len);
               phase_is_size_in    = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_is_size_ff <= 1'b0;
         pending_ff       <= '0;
         acc_ff           <= '0;
         cur_len_ff       <= '0;
         held_id_ff       <= '0;
         held_len_ff      <= '0;
      end else begin
         phase_is_size_ff <= phase_is_size_in;
         pending_ff       <= pending_in;
         acc_ff           <= acc_in;
         cur_len_ff       <= cur_len_in;
         held_id_ff       <= held_id_in;
         held_len_ff      <= held_len_in;
      end
   end

endmodule

FILE: design/ebml_back.sv
// Budget stage: charges the parent budget and holds the result register.
module ebml_back
   import ebml_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  ebml_entry_type  head_entry,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output ebml_result_type rsp_result
);

   logic               rsp_valid_ff, rsp_valid_in;
   ebml_result_type    rsp_ff,       rsp_in;
   logic [VALUE_W-1:0] budget_ff,    budget_in;
   logic               active_ff,    active_in;

   logic               emit;
   logic [LEN_W:0]     hdr;
   logic [VALUE_W-1:0] hdr_wide;
   logic               hdr_over;
   logic               total_over;
   logic [VALUE_W-1:0] after_hdr;
   logic [VALUE_W-1:0] after_total;
   logic [VALUE_W-1:0] new_budget;
   logic               new_zero;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   assign pop  = head_valid &&
                 (head_entry.kind == KIND_LOAD || !rsp_valid_ff || rsp_ready);
   assign emit = pop && head_entry.kind != KIND_LOAD;

   // Both compares and both differences in parallel; total = header + size.
   assign hdr         = (LEN_W+1)'(head_entry.id_len) + (LEN_W+1)'(head_entry.size_len);
   assign hdr_wide    = VALUE_W'(hdr);
   assign hdr_over    = hdr_wide > budget_ff;
   assign total_over  = head_entry.total > {1'b0, budget_ff};
   assign after_hdr   = budget_ff - hdr_wide;
   assign after_total = budget_ff - head_entry.total[VALUE_W-1:0];

   always_comb begin
      budget_in    = budget_ff;
      active_in    = active_ff;
      rsp_in       = rsp_ff;
      new_budget   = budget_ff;
      new_zero     = (budget_ff == '0);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (pop) begin
         case (head_entry.kind)
            KIND_LOAD: begin
               budget_in = head_entry.size;
               active_in = head_entry.bounded;
            end
            KIND_HEADER: begin
               rsp_in.status = STATUS_OK;
               if (active_ff) begin
                  if (hdr_over) begin
                     new_budget    = '0;
                     new_zero      = 1'b1;
                     rsp_in.status = STATUS_OVER_BUDGET;
                  end else if (total_over) begin
                     new_budget    = after_hdr;
                     new_zero      = (hdr_wide == budget_ff);
                     rsp_in.status = STATUS_OVER_BUDGET;
                  end else begin
                     new_budget = after_total;
                     new_zero   = (head_entry.total == {1'b0, budget_ff});
                  end
               end
               budget_in = new_budget;
            end
            KIND_ERROR: begin
               rsp_in.status = STATUS_BAD_LEAD;
            end
            default: begin
               rsp_in.status = STATUS_BAD_LEAD;
            end
         endcase
      end

      if (emit) begin
         rsp_valid_in    = 1'b1;
         rsp_in.id       = head_entry.id;
         rsp_in.size     = head_entry.size;
         rsp_in.id_len   = head_entry.id_len;
         rsp_in.size_len = head_entry.size_len;
         rsp_in.left     = active_ff ? new_budget : '0;
         rsp_in.done     = active_ff && new_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         budget_ff    <= '0;
         active_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         budget_ff    <= budget_in;
         active_ff    <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

FILE: design/ebml_element_header_parser.sv
// Top level of the EBML element header parser.
//
// Request channel (req_*): one word per cycle. req_tuser is the command:
// 0 loads a parent budget (parent_size, parent_bounded) and drops any partly
// decoded header; 1 carries one stream byte. Each header is an ID integer
// then a size integer, each 1 to MAX_VINT_BYTES bytes.
// Response channel (rsp_*): one word per finished header or per bad leading
// byte. rsp_tuser is the status (0 ok, 1 bad leading byte, 2 over budget);
// rsp_tlast is high when a bounded parent budget has run down to zero.
// Throughput: one request word per cycle, including loads, while the queue is not full.
// Path: the decoder writes the event for the last byte of a header into the
// queue at the edge that takes that byte; the budget stage then pops it and
// loads the response register, which drives the response word.
// Stalls: while rsp_tready is low the queue of QUEUE_DEPTH entries absorbs
// decoded events; req_tready falls only when that queue is full.
// Reset: queue and response register empty, decoder waits for an ID byte,
// budget is zero and unbounded.
`include "ebml_element_header_parser_defines.svh"

module ebml_element_header_parser
   import ebml_pkg::*;
#(
   parameter int MAX_VINT_BYTES = 8,
   parameter int QUEUE_DEPTH    = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // data_byte[7:0], parent_size[63:8], parent_bounded[64], zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // command[0]
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // element_id[55:0], element_size[111:56], id_length[115:112],
   // size_length[119:116], parent_left[175:120]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic [STATUS_W-1:0]    rsp_tuser,
   // parent_done
   output logic                   rsp_tlast
);

   logic            take;
   logic            q_push;
   ebml_entry_type  q_push_entry;
   logic            q_full;
   logic            q_pop;
   logic            q_head_valid;
   ebml_entry_type  q_head_entry;
   ebml_result_type result;

   assign req_tready = !q_full;
   assign take       = req_tvalid && req_tready;

   ebml_front #(
      .MAX_VINT_BYTES (MAX_VINT_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .take           (take),
      .command        (req_tuser),
      .data_byte      (req_tdata[7:0]),
      .parent_size    (req_tdata[VALUE_W+7:8]),
      .parent_bounded (req_tdata[VALUE_W+8]),
      .push_valid     (q_push),
      .push_entry     (q_push_entry)
   );

   ebml_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry)
   );

   ebml_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry),
      .pop        (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = {result.left, result.size_len, result.id_len, result.size, result.id};
   assign rsp_tuser = result.status;
   assign rsp_tlast = result.done;

   // Back stage only pops what the queue holds.
   `EBML_ASSERT_NOW(a_pop_has_entry, q_pop, q_head_valid)
   // A popped header or error shows up as a response word next cycle.
   `EBML_ASSERT_NEXT(a_pop_emits, q_pop && q_head_entry.kind != KIND_LOAD, rsp_tvalid)
   // A good header always carries both lengths.
   `EBML_ASSERT_NOW(a_ok_lengths, rsp_tvalid && result.status == STATUS_OK,
                    result.id_len != '0 && result.size_len != '0)
   // A bad leading byte never reports a size.
   `EBML_ASSERT_NOW(a_bad_lead_no_size, rsp_tvalid && result.status == STATUS_BAD_LEAD,
                    result.size == '0 && result.size_len == '0)

endmodule
